FILE: rtl/playback_time_accumulator_defines.svh
// ----------------------------------------------------------------------------
// Playback time accumulator assertion macros
// Shared concurrent assertion forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef PLAYBACK_TIME_ACCUMULATOR_DEFINES_SVH
`define PLAYBACK_TIME_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define PTA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define PTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pta_pkg.sv
// ----------------------------------------------------------------------------
// Playback time accumulator package
// Field widths, command codes, register map and item types.
// ----------------------------------------------------------------------------
package pta_pkg;

    localparam int OP_W    = 3;
    localparam int DELTA_W = 16;
    localparam int ELAP_W  = 32;
    localparam int SPEED_W = 5;
    localparam int STEP_W  = 5;
    localparam int PROD_W  = DELTA_W + SPEED_W;

    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // Command codes
    localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
    localparam logic [OP_W-1:0] OP_PLAY     = 3'd1;
    localparam logic [OP_W-1:0] OP_PLAY_REV = 3'd2;
    localparam logic [OP_W-1:0] OP_PAUSE    = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP     = 3'd4;
    localparam logic [OP_W-1:0] OP_FASTER   = 3'd5;
    localparam logic [OP_W-1:0] OP_SLOWER   = 3'd6;

    // Register select (word address bit 2)
    localparam logic REG_SPEED_STEP = 1'b0;
    localparam logic REG_END_TIME   = 1'b1;

    // Reset values
    localparam logic [STEP_W-1:0] SPEED_STEP_RST = 5'd1;
    localparam logic [ELAP_W-1:0] END_TIME_RST   = 32'd100000000;
    localparam logic [SPEED_W-1:0] SPEED_RST     = 5'd1;
    localparam int                 SPEED_MAX_DEF = 20;

    typedef struct packed {
        logic [DELTA_W-1:0] delta_ms;
        logic [OP_W-1:0]    op;
    } t_cmd;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               reverse;
        logic               paused;
        logic               playing;
        logic [DELTA_W-1:0] frame_delta_ms;
        logic [ELAP_W-1:0]  elapsed_ms;
    } t_result;

    typedef struct packed {
        logic [STEP_W-1:0] speed_step;
        logic [ELAP_W-1:0] end_time_ms;
    } t_cfg;

endpackage

FILE: rtl/pta_cfg.sv
// ----------------------------------------------------------------------------
// Playback time accumulator register file
// APB-style write/read of speed step and end time.
// ----------------------------------------------------------------------------
module pta_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pta_pkg::ADDR_W-1:0]  paddr,
    input  logic [pta_pkg::DATA_W-1:0]  pwdata,
    output logic [pta_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output pta_pkg::t_cfg               o_cfg
);
    import pta_pkg::*;

    logic [STEP_W-1:0] r_speed_step;
    logic [ELAP_W-1:0] r_end_time;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    // Low address bits are byte lanes and ignored; bit 2 selects the word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_step <= SPEED_STEP_RST;
            r_end_time   <= END_TIME_RST;
        end else if (w_wr) begin
            case (paddr[2])
                REG_SPEED_STEP: r_speed_step <= pwdata[STEP_W-1:0];
                REG_END_TIME:   r_end_time   <= pwdata[ELAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SPEED_STEP: prdata = DATA_W'(r_speed_step);
            REG_END_TIME:   prdata = DATA_W'(r_end_time);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.speed_step  = r_speed_step;
    assign o_cfg.end_time_ms = r_end_time;

endmodule

FILE: rtl/pta_in_stage.sv
// ----------------------------------------------------------------------------
// Playback time accumulator input register
// Holds one command item; refills in the cycle the core takes it.
// ----------------------------------------------------------------------------
module pta_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pta_pkg::t_cmd i_cmd,
    output logic          o_valid,
    output pta_pkg::t_cmd o_cmd,
    input  logic          i_take
);
    import pta_pkg::*;

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;

    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= i_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

FILE: rtl/pta_core.sv
// ----------------------------------------------------------------------------
// Playback time accumulator core
// Playback state, one-pass command update and the result register.
// ----------------------------------------------------------------------------
module pta_core #(
    parameter int MAX_SPEED = pta_pkg::SPEED_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  pta_pkg::t_cmd    i_cmd,
    output logic             o_take,
    input  pta_pkg::t_cfg    i_cfg,
    output logic             o_valid,
    output pta_pkg::t_result o_res,
    input  logic             i_ready
);
    import pta_pkg::*;

    localparam logic [SPEED_W:0] SpeedMax = (SPEED_W+1)'(MAX_SPEED);

    logic               r_play;
    logic               r_pause;
    logic               r_back;
    logic [SPEED_W-1:0] r_speed;
    logic [ELAP_W-1:0]  r_elapsed;

    logic               n_play;
    logic               n_pause;
    logic               n_back;
    logic [SPEED_W-1:0] n_speed;
    logic [ELAP_W-1:0]  n_elapsed;
    logic [DELTA_W-1:0] n_frame;

    logic               r_out_valid;
    t_result            r_res;

    logic [PROD_W-1:0]  w_prod;
    logic [ELAP_W:0]    w_fwd;
    logic [ELAP_W-1:0]  w_bwd;
    logic [ELAP_W:0]    w_move;
    logic [ELAP_W-1:0]  w_tick_time;
    logic [SPEED_W:0]   w_up;
    logic [SPEED_W-1:0] w_faster;
    logic [SPEED_W-1:0] w_slower;
    logic               w_fire;

    assign o_take = !r_out_valid || i_ready;
    assign w_fire = i_valid && o_take;

    // Tick arithmetic: 16x5 product, then add or floor-at-zero subtract,
    // then clamp to the end time.
    assign w_prod = PROD_W'(i_cmd.delta_ms) * PROD_W'(r_speed);
    assign w_fwd  = {1'b0, r_elapsed} + (ELAP_W+1)'(w_prod);
    assign w_bwd  = (ELAP_W'(w_prod) > r_elapsed) ? '0 : r_elapsed - ELAP_W'(w_prod);
    assign w_move = r_back ? {1'b0, w_bwd} : w_fwd;
    assign w_tick_time = (w_move > {1'b0, i_cfg.end_time_ms}) ? i_cfg.end_time_ms
                                                             : w_move[ELAP_W-1:0];

    // Speed stepping with saturation at 1 and MAX_SPEED
    assign w_up     = {1'b0, r_speed} + (SPEED_W+1)'(i_cfg.speed_step);
    assign w_faster = (w_up > SpeedMax) ? SpeedMax[SPEED_W-1:0] : w_up[SPEED_W-1:0];
    assign w_slower = (r_speed <= SPEED_W'(i_cfg.speed_step))
                    ? SPEED_RST : r_speed - SPEED_W'(i_cfg.speed_step);

    always_comb begin
        n_play    = r_play;
        n_pause   = r_pause;
        n_back    = r_back;
        n_speed   = r_speed;
        n_elapsed = r_elapsed;
        n_frame   = '0;
        case (i_cmd.op)
            OP_TICK: begin
                n_frame = i_cmd.delta_ms;
                if (r_play) begin
                    n_elapsed = w_tick_time;
                end else if (r_pause) begin
                    n_frame = '0;
                end
            end
            OP_PLAY: begin
                n_pause = 1'b0;
                n_back  = 1'b0;
                n_play  = 1'b1;
            end
            OP_PLAY_REV: begin
                n_pause = 1'b0;
                n_back  = 1'b1;
                n_play  = 1'b1;
            end
            OP_PAUSE: begin
                n_play  = 1'b0;
                n_pause = 1'b1;
            end
            OP_STOP: begin
                n_play    = 1'b0;
                n_pause   = 1'b1;
                n_elapsed = '0;
            end
            OP_FASTER: n_speed = w_faster;
            OP_SLOWER: n_speed = w_slower;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play      <= 1'b0;
            r_pause     <= 1'b0;
            r_back      <= 1'b0;
            r_speed     <= SPEED_RST;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_play    <= n_play;
                r_pause   <= n_pause;
                r_back    <= n_back;
                r_speed   <= n_speed;
                r_elapsed <= n_elapsed;
            end
            r_out_valid <= w_fire || (r_out_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res.elapsed_ms     <= n_elapsed;
            r_res.frame_delta_ms <= n_frame;
            r_res.playing        <= n_play;
            r_res.paused         <= n_pause;
            r_res.reverse        <= n_back;
            r_res.speed          <= n_speed;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

endmodule

FILE: rtl/playback_time_accumulator.sv
// ----------------------------------------------------------------------------
// Playback time accumulator
// Simulation playback clock driven by one command item per handshake.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries commands: tuser = op (tick, play, play backward, pause,
//   stop, faster, slower), tdata = delta_ms in real milliseconds (tick only).
//   m_axis returns exactly one result item per command: elapsed playback
//   time, frame delta, play/pause/reverse flags and the current speed.
//   APB port: word 0 = speed_step, word 1 = end_time_ms (elapsed clamp).
//   Write registers only while no command is in flight.
// Path and throughput:
//   An accepted command passes through the input register, then the result
//   register, before its result is offered on m_axis. One item per cycle
//   sustained while m_axis_tready stays high; the state update (16x5 multiply,
//   33-bit add/subtract, clamp to end time) is combinational between them.
// Reset:
//   Synchronous, active low. Stopped-idle state: not playing, not paused,
//   forward, speed 1, elapsed 0; speed_step 1, end_time_ms 100000000.
// Stalls:
//   When m_axis_tready is low the result holds; the input register keeps
//   accepting until it too is full, then s_axis_tready drops.
// ----------------------------------------------------------------------------
`include "playback_time_accumulator_defines.svh"

module playback_time_accumulator #(
    parameter int MAX_SPEED = pta_pkg::SPEED_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Command channel
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [15:0]                s_axis_tdata,  // [15:0] delta_ms
    input  logic [2:0]                 s_axis_tuser,  // [2:0] op
    // Result channel
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [31:0] elapsed_ms, [47:32] frame_delta_ms, [48] playing,
    // [49] paused, [50] reverse, [55:51] speed
    output logic [55:0]                m_axis_tdata,
    // Register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pta_pkg::ADDR_W-1:0] paddr,
    input  logic [pta_pkg::DATA_W-1:0] pwdata,
    output logic [pta_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import pta_pkg::*;

    t_cmd    w_s_cmd;
    t_cmd    w_cmd;
    logic    w_cmd_valid;
    logic    w_take;
    t_cfg    w_cfg;
    t_result w_res;

    assign w_s_cmd.op       = s_axis_tuser;
    assign w_s_cmd.delta_ms = s_axis_tdata;

    pta_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Input register: decouples s_axis from the state update
    pta_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cmd   (w_s_cmd),
        .o_valid (w_cmd_valid),
        .o_cmd   (w_cmd),
        .i_take  (w_take)
    );

    // Playback state and result register
    pta_core #(
        .MAX_SPEED (MAX_SPEED)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cmd_valid),
        .i_cmd   (w_cmd),
        .o_take  (w_take),
        .i_cfg   (w_cfg),
        .o_valid (m_axis_tvalid),
        .o_res   (w_res),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = w_res;

    // Speed never leaves its saturation window.
    `PTA_ASSERT_NOW(a_speed_range, i_clk, i_rst_n, m_axis_tvalid,
        (w_res.speed != '0) && (w_res.speed <= SPEED_W'(MAX_SPEED)),
        "speed outside 1..MAX_SPEED")
    // Playing and paused are mutually exclusive.
    `PTA_ASSERT_NOW(a_play_pause_excl, i_clk, i_rst_n, m_axis_tvalid,
        !(w_res.playing && w_res.paused), "playing and paused both set")
    // A nonzero frame delta only comes from an unpaused tick.
    `PTA_ASSERT_NOW(a_frame_unpaused, i_clk, i_rst_n,
        m_axis_tvalid && (w_res.frame_delta_ms != '0), !w_res.paused,
        "frame delta reported while paused")
    // An accepted command is held in the input register next cycle.
    `PTA_ASSERT_NEXT(a_cmd_captured, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, w_cmd_valid,
        "accepted command not captured")

endmodule

FILE: sim/tb_playback_time_accumulator.sv
// ----------------------------------------------------------------------------
// Playback time accumulator testbench
// Drives command items and register writes into the playback clock. A local
// model of the clock predicts every result item, and each result is checked
// field by field against the oldest prediction. A directed table runs first,
// then random phases under changing register settings and handshake idling.
// ----------------------------------------------------------------------------
module tb_playback_time_accumulator;
    import pta_pkg::*;

    // Op code 7 has no command; the block reports its state unchanged.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    // Byte addresses of the two registers.
    localparam logic [ADDR_W-1:0] ADDR_SPEED_STEP = {REG_SPEED_STEP, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_END_TIME   = {REG_END_TIME, 2'b00};

    localparam logic [SPEED_W-1:0] SPEED_FLOOR = 5'd1;

    localparam int RESET_CYCLES   = 10;
    localparam int DRAIN_CYCLES   = 4;    // result path is two registers deep
    localparam int HOLD_CYCLES    = 64;   // long receiver hold-off
    localparam int STALL_LIMIT    = 3000; // cycles with no handshake at all
    localparam int RAND_PHASES    = 6;
    localparam int PHASE_ITEMS    = 142;
    localparam int MAX_PRINTED    = 50;

    typedef enum logic {ROW_CMD, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        t_cmd              cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] value;
        logic              typed;   // expected result given in the row
        t_result           res;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata;   // [15:0] delta_ms
    logic [2:0]        s_axis_tuser;   // [2:0] op
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    // [31:0] elapsed_ms, [47:32] frame_delta_ms, [48] playing,
    // [49] paused, [50] reverse, [55:51] speed
    logic [55:0]       m_axis_tdata;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    playback_time_accumulator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Local copy of the clock state and of the registers.
    logic              clk_playing;
    logic              clk_paused;
    logic              clk_reverse;
    logic [SPEED_W-1:0] clk_speed;
    logic [ELAP_W-1:0]  clk_elapsed;
    logic [STEP_W-1:0]  cfg_step;
    logic [ELAP_W-1:0]  cfg_end;

    t_result pending_results[$];

    int err_cnt       = 0;
    int snd_idle_pct  = 0;
    int rcv_idle_pct  = 0;
    logic hold_request = 1'b0;

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTED)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // Applies one command to the local clock and returns the result it gives.
    function automatic t_result advance_clock(input t_cmd cmd);
        t_result            r;
        logic [PROD_W-1:0]  prod;
        logic [ELAP_W:0]    t;
        int                 sp;
        r.frame_delta_ms = '0;
        case (cmd.op)
            OP_TICK: begin
                prod = PROD_W'(cmd.delta_ms) * PROD_W'(clk_speed);
                r.frame_delta_ms = cmd.delta_ms;
                if (clk_playing) begin
                    t = {1'b0, clk_elapsed};
                    if (clk_reverse)
                        t = ((ELAP_W+1)'(prod) > t) ? '0 : t - (ELAP_W+1)'(prod);
                    else
                        t = t + (ELAP_W+1)'(prod);
                    // clamp applies in both directions, so a lowered end
                    // time pulls a larger elapsed time down
                    if (t > {1'b0, cfg_end})
                        t = {1'b0, cfg_end};
                    clk_elapsed = t[ELAP_W-1:0];
                end else if (clk_paused) begin
                    r.frame_delta_ms = '0;
                end
            end
            OP_PLAY: begin
                clk_paused  = 1'b0;
                clk_reverse = 1'b0;
                clk_playing = 1'b1;
            end
            OP_PLAY_REV: begin
                clk_paused  = 1'b0;
                clk_reverse = 1'b1;
                clk_playing = 1'b1;
            end
            OP_PAUSE: begin
                clk_playing = 1'b0;
                clk_paused  = 1'b1;
            end
            OP_STOP: begin
                clk_playing = 1'b0;
                clk_paused  = 1'b1;
                clk_elapsed = '0;
            end
            OP_FASTER: begin
                sp = int'(clk_speed) + int'(cfg_step);
                if (sp > SPEED_MAX_DEF)
                    sp = SPEED_MAX_DEF;
                clk_speed = sp[SPEED_W-1:0];
            end
            OP_SLOWER: begin
                if (clk_speed <= cfg_step)
                    clk_speed = SPEED_FLOOR;
                else
                    clk_speed = clk_speed - cfg_step;
            end
            default: begin
            end
        endcase
        r.elapsed_ms = clk_elapsed;
        r.playing    = clk_playing;
        r.paused     = clk_paused;
        r.reverse    = clk_reverse;
        r.speed      = clk_speed;
        return r;
    endfunction

    function automatic t_row cmd_row(input logic [OP_W-1:0] op,
                                     input logic [DELTA_W-1:0] delta);
        t_row r;
        r = '0;
        r.kind         = ROW_CMD;
        r.cmd.op       = op;
        r.cmd.delta_ms = delta;
        return r;
    endfunction

    function automatic t_row cmd_row_typed(input logic [OP_W-1:0] op,
                                           input logic [DELTA_W-1:0] delta,
                                           input logic [ELAP_W-1:0] el,
                                           input logic [DELTA_W-1:0] fr,
                                           input logic pl, input logic pa,
                                           input logic rv,
                                           input logic [SPEED_W-1:0] sp);
        t_row r;
        r = cmd_row(op, delta);
        r.typed              = 1'b1;
        r.res.elapsed_ms     = el;
        r.res.frame_delta_ms = fr;
        r.res.playing        = pl;
        r.res.paused         = pa;
        r.res.reverse        = rv;
        r.res.speed          = sp;
        return r;
    endfunction

    function automatic t_row cfg_row(input logic [ADDR_W-1:0] addr,
                                     input logic [DATA_W-1:0] value);
        t_row r;
        r = '0;
        r.kind  = ROW_CFG;
        r.addr  = addr;
        r.value = value;
        return r;
    endfunction

    // Offers one command item, holding it until accepted. Starts and ends at
    // a falling edge; valid stays high on exit so back-to-back items flow.
    task automatic send_cmd(input t_cmd cmd, input logic use_typed,
                            input t_result typed);
        t_result want;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd.op;
        s_axis_tdata  <= cmd.delta_ms;
        do @(posedge i_clk); while (!s_axis_tready);
        want = advance_clock(cmd);
        pending_results.push_back(use_typed ? typed : want);
        @(negedge i_clk);
    endtask

    // Two-phase register write; pready is sampled in the access cycle.
    task automatic apb_write(input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_SPEED_STEP)
            cfg_step = value[STEP_W-1:0];
        else
            cfg_end = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Waits until every predicted result has been seen, plus the pipe depth.
    task automatic drain_results;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0: begin snd_idle_pct = 19; rcv_idle_pct = 78; end
            1: begin snd_idle_pct = 78; rcv_idle_pct = 19; end
            default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
        endcase
    endtask

    function automatic logic [OP_W-1:0] pick_op;
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)      return OP_TICK;
        else if (r < 60) return OP_PLAY;
        else if (r < 68) return OP_PLAY_REV;
        else if (r < 74) return OP_PAUSE;
        else if (r < 78) return OP_STOP;
        else if (r < 87) return OP_FASTER;
        else if (r < 96) return OP_SLOWER;
        else             return OP_UNUSED;
    endfunction

    function automatic logic [DELTA_W-1:0] pick_delta;
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)      return '0;
        else if (r == 1) return '1;
        else if (r < 6)  return DELTA_W'($urandom_range(0, 255));
        else             return DELTA_W'($urandom);
    endfunction

    // Receiver: ready changes at the falling edge; a hold-off request from
    // the stimulus side is counted down here.
    initial begin : result_ready
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_results.size() == 0) begin
                flag_error("result item with no command outstanding");
            end else begin
                want = pending_results.pop_front();
                if (got.elapsed_ms !== want.elapsed_ms)
                    flag_error($sformatf("elapsed_ms %0d, want %0d",
                                         got.elapsed_ms, want.elapsed_ms));
                if (got.frame_delta_ms !== want.frame_delta_ms)
                    flag_error($sformatf("frame_delta_ms %0d, want %0d",
                                         got.frame_delta_ms, want.frame_delta_ms));
                if (got.playing !== want.playing)
                    flag_error($sformatf("playing %b, want %b",
                                         got.playing, want.playing));
                if (got.paused !== want.paused)
                    flag_error($sformatf("paused %b, want %b",
                                         got.paused, want.paused));
                if (got.reverse !== want.reverse)
                    flag_error($sformatf("reverse %b, want %b",
                                         got.reverse, want.reverse));
                if (got.speed !== want.speed)
                    flag_error($sformatf("speed %0d, want %0d",
                                         got.speed, want.speed));
            end
        end
    end

    // Watchdog: any handshake on either stream or a register write resets it.
    always @(posedge i_clk) begin : stall_watch
        int quiet;
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pwrite && pready)) begin
            quiet = 0;
        end else begin
            quiet = quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $display("playback_time_accumulator regression: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_row    dir_rows[$];
        t_row    row;
        t_cmd    cmd;
        logic [DATA_W-1:0] end_val;
        logic [DATA_W-1:0] step_val;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_TICK;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;

        clk_playing = 1'b0;
        clk_paused  = 1'b0;
        clk_reverse = 1'b0;
        clk_speed   = SPEED_RST;
        clk_elapsed = '0;
        cfg_step    = SPEED_STEP_RST;
        cfg_end     = END_TIME_RST;

        // Directed table. Rows with a typed result are checked against it.
        // idle tick still reports its delta; op 7 changes nothing
        dir_rows.push_back(cmd_row_typed(OP_TICK, 16'hFFFF,
            32'd0, 16'hFFFF, 1'b0, 1'b0, 1'b0, 5'd1));
        dir_rows.push_back(cmd_row_typed(OP_UNUSED, 16'h1234,
            32'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 5'd1));
        dir_rows.push_back(cmd_row_typed(OP_PLAY, 16'h0000,
            32'd0, 16'h0000, 1'b1, 1'b0, 1'b0, 5'd1));
        dir_rows.push_back(cmd_row_typed(OP_TICK, 16'hFFFF,
            32'd65535, 16'hFFFF, 1'b1, 1'b0, 1'b0, 5'd1));
        dir_rows.push_back(cmd_row_typed(OP_TICK, 16'h0000,
            32'd65535, 16'h0000, 1'b1, 1'b0, 1'b0, 5'd1));
        dir_rows.push_back(cmd_row_typed(OP_FASTER, 16'h0000,
            32'd65535, 16'h0000, 1'b1, 1'b0, 1'b0, 5'd2));
        // largest legal step saturates at the top speed
        dir_rows.push_back(cfg_row(ADDR_SPEED_STEP, 32'd19));
        dir_rows.push_back(cmd_row(OP_FASTER, 16'h0000));
        dir_rows.push_back(cmd_row(OP_TICK, 16'hFFFF));
        // backward: a partial step, then underflow to zero
        dir_rows.push_back(cmd_row(OP_PLAY_REV, 16'hFFFF));
        dir_rows.push_back(cmd_row(OP_TICK, 16'hAAAA));
        dir_rows.push_back(cmd_row(OP_TICK, 16'hFFFF));
        dir_rows.push_back(cmd_row(OP_SLOWER, 16'h0000));
        dir_rows.push_back(cmd_row(OP_SLOWER, 16'h0000));
        // clamp at an end time of zero, then above a lowered end time
        dir_rows.push_back(cfg_row(ADDR_END_TIME, 32'd0));
        dir_rows.push_back(cmd_row(OP_PLAY, 16'h0000));
        dir_rows.push_back(cmd_row(OP_TICK, 16'hFFFF));
        dir_rows.push_back(cfg_row(ADDR_END_TIME, 32'd1000));
        dir_rows.push_back(cmd_row(OP_TICK, 16'd5000));
        dir_rows.push_back(cfg_row(ADDR_END_TIME, 32'd10));
        dir_rows.push_back(cmd_row(OP_TICK, 16'h0000));
        dir_rows.push_back(cmd_row(OP_PLAY_REV, 16'h0000));
        dir_rows.push_back(cfg_row(ADDR_END_TIME, 32'd5));
        dir_rows.push_back(cmd_row(OP_TICK, 16'd1));
        // paused tick reports no frame delta; stop clears the time
        dir_rows.push_back(cmd_row(OP_PAUSE, 16'h0000));
        dir_rows.push_back(cmd_row(OP_TICK, 16'h5555));
        dir_rows.push_back(cmd_row(OP_STOP, 16'h0000));
        // zero step leaves the speed alone; an oversized step saturates
        dir_rows.push_back(cfg_row(ADDR_SPEED_STEP, 32'd0));
        dir_rows.push_back(cmd_row(OP_FASTER, 16'h0000));
        dir_rows.push_back(cfg_row(ADDR_SPEED_STEP, 32'd31));
        dir_rows.push_back(cmd_row(OP_FASTER, 16'h0000));
        dir_rows.push_back(cmd_row(OP_SLOWER, 16'h0000));

        set_idle_mode(0);
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < dir_rows.size(); i++) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG) begin
                s_axis_tvalid <= 1'b0;
                drain_results();
                apb_write(row.addr, row.value);
            end else begin
                send_cmd(row.cmd, row.typed, row.res);
            end
        end

        // Random phases, each under its own register setting and idling.
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: begin step_val = 32'd1;  end_val = 32'hFFFF_FFFF; end
                1: begin step_val = 32'd19; end_val = $urandom_range(1000, 200000); end
                2: begin step_val = $urandom_range(1, 19); end_val = END_TIME_RST; end
                3: begin step_val = 32'd0;  end_val = 32'd0; end
                4: begin step_val = 32'd31; end_val = $urandom; end
                default: begin
                    step_val = $urandom_range(2, 6);
                    end_val  = $urandom_range(1, 5000000);
                end
            endcase
            s_axis_tvalid <= 1'b0;
            drain_results();
            apb_write(ADDR_SPEED_STEP, step_val);
            apb_write(ADDR_END_TIME, end_val);
            set_idle_mode(p % 3);
            // no idling on either side: hold the receiver off so the
            // block fills and drops its ready
            if (p % 3 == 2)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                cmd.op       = pick_op();
                cmd.delta_ms = pick_delta();
                send_cmd(cmd, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0)
            $display("playback_time_accumulator regression: pass");
        else
            $display("playback_time_accumulator regression: fail");
        $finish;
    end

endmodule
